@@ rtl/oaid_pkg.sv @@
// Package for the ordered array insert/delete block.
// Holds the transfer payload types, command and status codes, and the cell control struct.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package oaid_pkg;

  localparam int unsigned POS_BITS = 8;
  localparam int unsigned ELEM_BITS = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [POS_BITS-1:0]         position;
    logic signed [ELEM_BITS-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  result_status;
    logic signed [ELEM_BITS-1:0] element_out;
    logic [POS_BITS-1:0]         count_out;
  } out_item_t;

  // Broadcast to every cell for one cycle when an operation is committed.
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/oaid_cell.sv @@
// One storage cell of the list chain: holds a single word and moves it to or from a neighbor.
// Depends on oaid_pkg for the cell control struct.
`default_nettype none

module oaid_cell
  import oaid_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned XW        = 9,
  parameter int unsigned INDEX     = 0
) (
  input  wire logic                 clk_i,
  input  wire cell_ctl_t            ctl_i,
  input  wire logic [XW-1:0]        idx_i,
  input  wire logic [WORD_BITS-1:0] value_i,
  input  wire logic [WORD_BITS-1:0] left_i,
  input  wire logic [WORD_BITS-1:0] right_i,
  output logic      [WORD_BITS-1:0] word_o,
  output logic      [WORD_BITS-1:0] tap_o
);

  localparam logic [XW-1:0] MyIdx = XW'(INDEX);

  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] word_d;
  logic                 at_idx;
  logic                 above_idx;

  assign at_idx    = (MyIdx == idx_i);
  assign above_idx = (MyIdx > idx_i);

  // Insert opens a hole at the target and pushes everything above it one cell up;
  // delete pulls everything from the target upward one cell down.
  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (at_idx) begin
        word_d = value_i;
      end else if (above_idx) begin
        word_d = left_i;
      end
    end else if (ctl_i.del) begin
      if (at_idx || above_idx) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = ((ctl_i.del || ctl_i.rd) && at_idx) ? word_q : '0;

endmodule

`default_nettype wire

@@ rtl/oaid_or_tree.sv @@
// Registered binary OR tree that gathers the one selected cell word onto a single bus.
// Depends on oaid_pkg only by house convention; no types from it are needed beyond import.
`default_nettype none

module oaid_or_tree
  import oaid_pkg::*;
#(
  parameter int unsigned W = 32,
  parameter int unsigned N = 128
) (
  input  wire logic         clk_i,
  input  wire logic         load_i,
  input  wire logic [W-1:0] leaf_i [N],
  output logic      [W-1:0] root_o
);

  localparam int unsigned L  = $clog2(N);
  localparam int unsigned N2 = 1 << L;

  // Heap layout: node 1 is the root, leaves sit at N2 .. 2*N2-1.
  logic [W-1:0] node_q [1:2*N2-1];

  for (genvar k = N2; k < 2 * N2; k++) begin : g_leaf
    if (k - N2 < N) begin : g_used
      always_ff @(posedge clk_i) begin
        if (load_i) begin
          node_q[k] <= leaf_i[k-N2];
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < N2; k++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[k] <= node_q[2*k] | node_q[2*k+1];
    end
  end

  assign root_o = node_q[1];

endmodule

`default_nettype wire

@@ rtl/ordered_array_insert_delete_top.sv @@
// Ordered list with insert, delete and read by one-based position, built as a chain of cells.
// Each result passes through the registered OR tree that gathers the selected word from the cells.
// One item is handled at a time; a new item may enter while a result waits at the output.
// Reset (asynchronous, active low) empties the list and clears all handshake state.
// Depends on oaid_pkg, oaid_cell and oaid_or_tree.
`default_nettype none

module ordered_array_insert_delete_top
  import oaid_pkg::*;
#(
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = ((CW > POS_BITS) ? CW : POS_BITS) + 1;
  localparam int unsigned LVL = $clog2(DEPTH);
  localparam int unsigned LCW = $clog2(LVL + 1);
  localparam logic [XW-1:0]  DepthX = XW'(DEPTH);
  localparam logic [LCW-1:0] LvlC   = LCW'(LVL);

  logic [CW-1:0]  count_q, count_d;
  logic           busy_q;
  logic [LCW-1:0] lat_q;
  status_e        stat_q, stat_d;
  logic           out_valid_q;
  out_item_t      out_data_q;

  logic           accept;
  logic           out_load;
  logic [XW-1:0]  pos_x, count_x, idx_x;
  logic           pos_nz;
  cell_ctl_t      ctl_d, ctl;
  logic [63:0]    val_ext;
  logic [WORD_BITS-1:0] val_word;

  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] taps  [DEPTH];
  logic [WORD_BITS-1:0] root;
  logic [WORD_BITS+63:0] root_ext;
  logic [CW+7:0]        count_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;

  assign pos_x   = {{(XW - POS_BITS){1'b0}}, in_data_i.position};
  assign count_x = {{(XW - CW){1'b0}}, count_q};
  assign idx_x   = pos_x - XW'(1);
  assign pos_nz  = (in_data_i.position != '0);

  assign val_ext  = {{32{in_data_i.new_value[ELEM_BITS-1]}}, in_data_i.new_value};
  assign val_word = val_ext[WORD_BITS-1:0];

  // Range is checked before fullness, so a bad position in a full list reports a range error.
  always_comb begin
    ctl_d   = '0;
    stat_d  = ST_RANGE;
    count_d = count_q;
    unique case (in_data_i.cmd)
      CMD_INSERT: begin
        if (pos_nz && (pos_x <= count_x + XW'(1))) begin
          if (count_x == DepthX) begin
            stat_d = ST_FULL;
          end else begin
            stat_d    = ST_OK;
            ctl_d.ins = 1'b1;
            count_d   = count_q + CW'(1);
          end
        end
      end
      CMD_DELETE: begin
        if (pos_nz && (pos_x <= count_x)) begin
          stat_d    = ST_OK;
          ctl_d.del = 1'b1;
          count_d   = count_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_nz && (pos_x <= count_x)) begin
          stat_d   = ST_OK;
          ctl_d.rd = 1'b1;
        end
      end
      default: begin
        stat_d = ST_RANGE;
      end
    endcase
  end

  assign ctl = accept ? ctl_d : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_right
      assign right_w = words[i+1];
    end
    oaid_cell #(
      .WORD_BITS (WORD_BITS),
      .XW        (XW),
      .INDEX     (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (idx_x),
      .value_i (val_word),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .tap_o   (taps[i])
    );
  end

  oaid_or_tree #(
    .W (WORD_BITS),
    .N (DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .load_i (accept),
    .leaf_i (taps),
    .root_o (root)
  );

  assign root_ext  = {64'd0, root};
  assign count_ext = {8'd0, count_q};
  assign out_load  = busy_q && (lat_q == '0) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      lat_q       <= '0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        stat_q  <= stat_d;
        busy_q  <= 1'b1;
        lat_q   <= LvlC;
      end else if (lat_q != '0) begin
        lat_q <= lat_q - LCW'(1);
      end
      if (out_load) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.result_status <= stat_q;
      out_data_q.element_out   <= root_ext[ELEM_BITS-1:0];
      out_data_q.count_out     <= count_ext[POS_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length exceeds depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctl_d.ins |=> count_q == $past(count_q) + CW'(1))
    else $error("successful insert did not grow the list");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && (lat_q == LvlC))
    else $error("accepted item did not start the gather sequence");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_status != ST_OK) |-> out_data_o.element_out == '0)
    else $error("error result carries a nonzero element");
`endif

endmodule

`default_nettype wire
